/* hdl/lbm_d3q19_moment_unit_assert.svh */
// Assertion macros for the D3Q19 moment unit.
// Used by lbm_mom_back, which checks its own control logic; no other dependency.
`ifndef LBM_D3Q19_MOMENT_UNIT_ASSERT_SVH
`define LBM_D3Q19_MOMENT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on clk_i, ignored while rst_ni is low
`define LBM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Property checked on clk_i at every edge, reset included
`define LBM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LBM_ASSERT(name, prop, msg)
`define LBM_ASSERT_RST(name, prop, msg)
`endif

`endif

/* hdl/lbm_mom_pkg.sv */
// Shared types, constants and helper functions of the D3Q19 moment unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbm_mom_pkg;

  localparam int unsigned DIR_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned WIDE_W   = 66;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [DIR_W-1:0] FIRST_DIR = 5'd0;
  localparam logic [DIR_W-1:0] LAST_DIR  = 5'd18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_TENSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_FORCE_Z    = 1'b1;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sign_e;

  typedef struct packed {
    sign_e x;
    sign_e y;
    sign_e z;
  } dir_sign_t;

  // One finished cell, handed from the front to the back
  typedef struct packed {
    logic signed [ACC_W-1:0]  density;
    logic signed [ACC_W-1:0]  mom_x;
    logic signed [ACC_W-1:0]  mom_y;
    logic signed [ACC_W-1:0]  mom_z;
    logic                     solid;
    logic signed [DATA_W-1:0] curvature;
    logic signed [DATA_W-1:0] normal_magnitude;
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic signed [DATA_W-1:0] normal_z;
    logic signed [DATA_W-1:0] phase;
  } cell_rec_t;

  // D3Q19 velocity set: sign of each axis per direction
  function automatic dir_sign_t dir_sign(input logic [DIR_W-1:0] dir);
    dir_sign_t s;
    s = '{x: SGN_ZERO, y: SGN_ZERO, z: SGN_ZERO};
    unique case (dir)
      5'd1:  s = '{x: SGN_POS,  y: SGN_ZERO, z: SGN_ZERO};
      5'd2:  s = '{x: SGN_NEG,  y: SGN_ZERO, z: SGN_ZERO};
      5'd3:  s = '{x: SGN_ZERO, y: SGN_POS,  z: SGN_ZERO};
      5'd4:  s = '{x: SGN_ZERO, y: SGN_NEG,  z: SGN_ZERO};
      5'd5:  s = '{x: SGN_ZERO, y: SGN_ZERO, z: SGN_POS};
      5'd6:  s = '{x: SGN_ZERO, y: SGN_ZERO, z: SGN_NEG};
      5'd7:  s = '{x: SGN_POS,  y: SGN_POS,  z: SGN_ZERO};
      5'd8:  s = '{x: SGN_NEG,  y: SGN_POS,  z: SGN_ZERO};
      5'd9:  s = '{x: SGN_POS,  y: SGN_NEG,  z: SGN_ZERO};
      5'd10: s = '{x: SGN_NEG,  y: SGN_NEG,  z: SGN_ZERO};
      5'd11: s = '{x: SGN_POS,  y: SGN_ZERO, z: SGN_POS};
      5'd12: s = '{x: SGN_NEG,  y: SGN_ZERO, z: SGN_POS};
      5'd13: s = '{x: SGN_POS,  y: SGN_ZERO, z: SGN_NEG};
      5'd14: s = '{x: SGN_NEG,  y: SGN_ZERO, z: SGN_NEG};
      5'd15: s = '{x: SGN_ZERO, y: SGN_POS,  z: SGN_POS};
      5'd16: s = '{x: SGN_ZERO, y: SGN_NEG,  z: SGN_POS};
      5'd17: s = '{x: SGN_ZERO, y: SGN_POS,  z: SGN_NEG};
      5'd18: s = '{x: SGN_ZERO, y: SGN_NEG,  z: SGN_NEG};
      default: s = '{x: SGN_ZERO, y: SGN_ZERO, z: SGN_ZERO};
    endcase
    return s;
  endfunction

  // Apply a direction sign to an accumulator term
  function automatic logic signed [ACC_W-1:0] signed_term(
    input sign_e                   s,
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    r = '0;
    unique case (s)
      SGN_POS:  r = v;
      SGN_NEG:  r = -v;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic fits;
    fits = (&x[WIDE_W-1:DATA_W-1]) || (~|x[WIDE_W-1:DATA_W-1]);
    if (fits) begin
      return x[DATA_W-1:0];
    end else if (x[WIDE_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/lbm_mom_fifo.sv */
// Short queue of finished cell records between the front and the back.
// Depends on lbm_mom_pkg for the record type and the depth.
`default_nettype none

module lbm_mom_fifo
  import lbm_mom_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire cell_rec_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output cell_rec_t      data_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cell_rec_t              mem_q [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/lbm_mom_front.sv */
// Front of the moment unit: accepts direction items and accumulates the sums.
// Depends on lbm_mom_pkg; pushes one record per cell into lbm_mom_fifo.
`default_nettype none

module lbm_mom_front
  import lbm_mom_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [DIR_W-1:0]         direction_i,
  input  wire logic signed [DATA_W-1:0] pdf_first_i,
  input  wire logic signed [DATA_W-1:0] pdf_second_i,
  input  wire logic                     solid_i,
  input  wire logic signed [DATA_W-1:0] curvature_i,
  input  wire logic signed [DATA_W-1:0] normal_magnitude_i,
  input  wire logic signed [DATA_W-1:0] normal_x_i,
  input  wire logic signed [DATA_W-1:0] normal_y_i,
  input  wire logic signed [DATA_W-1:0] normal_z_i,
  input  wire logic signed [DATA_W-1:0] phase_in_i,
  output logic                          push_o,
  output cell_rec_t                     rec_o
);

  logic signed [ACC_W-1:0] dens_q, dens_d;
  logic signed [ACC_W-1:0] mx_q, mx_d;
  logic signed [ACC_W-1:0] my_q, my_d;
  logic signed [ACC_W-1:0] mz_q, mz_d;
  logic signed [ACC_W-1:0] dens_new, mx_new, my_new, mz_new;
  logic signed [DATA_W:0]  pdf_sum;
  logic signed [ACC_W-1:0] term;
  logic                    dir_ok, dir_first, dir_last;
  dir_sign_t               sgn;

  assign dir_ok    = (direction_i <= LAST_DIR);
  assign dir_first = (direction_i == FIRST_DIR);
  assign dir_last  = (direction_i == LAST_DIR);
  assign sgn       = dir_sign(direction_i);
  assign pdf_sum   = (DATA_W+1)'(pdf_first_i) + (DATA_W+1)'(pdf_second_i);
  assign term      = ACC_W'(pdf_sum);

  // Add this direction's contribution; a starting direction restarts from zero
  always_comb begin
    if (dir_first) begin
      dens_new = term;
      mx_new   = signed_term(sgn.x, term);
      my_new   = signed_term(sgn.y, term);
      mz_new   = signed_term(sgn.z, term);
    end else begin
      dens_new = dens_q + term;
      mx_new   = mx_q + signed_term(sgn.x, term);
      my_new   = my_q + signed_term(sgn.y, term);
      mz_new   = mz_q + signed_term(sgn.z, term);
    end
  end

  // Update sums; the closing direction hands them on and clears
  always_comb begin
    dens_d = dens_q;
    mx_d   = mx_q;
    my_d   = my_q;
    mz_d   = mz_q;
    push_o = 1'b0;
    if (accept_i && dir_ok) begin
      if (dir_last) begin
        dens_d = '0;
        mx_d   = '0;
        my_d   = '0;
        mz_d   = '0;
        push_o = 1'b1;
      end else begin
        dens_d = dens_new;
        mx_d   = mx_new;
        my_d   = my_new;
        mz_d   = mz_new;
      end
    end
  end

  assign rec_o = '{
    density:          dens_new,
    mom_x:            mx_new,
    mom_y:            my_new,
    mom_z:            mz_new,
    solid:            solid_i,
    curvature:        curvature_i,
    normal_magnitude: normal_magnitude_i,
    normal_x:         normal_x_i,
    normal_y:         normal_y_i,
    normal_z:         normal_z_i,
    phase:            phase_in_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dens_q <= '0;
      mx_q   <= '0;
      my_q   <= '0;
      mz_q   <= '0;
    end else begin
      dens_q <= dens_d;
      mx_q   <= mx_d;
      my_q   <= my_d;
      mz_q   <= mz_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/lbm_mom_back.sv */
// Back of the moment unit: force chain on one shared multiplier, result register.
// Depends on lbm_mom_pkg and the assertion macro header.
`default_nettype none

`include "lbm_d3q19_moment_unit_assert.svh"

module lbm_mom_back
  import lbm_mom_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [DATA_W-1:0] gamma_i,
  input  wire logic signed [DATA_W-1:0] body_force_z_i,
  input  wire logic                     q_empty_i,
  input  wire cell_rec_t                rec_i,
  output logic                          q_pop_o,
  output logic                          empty_o,
  input  wire logic                     pop_i,
  output logic signed [DATA_W-1:0]      density_o,
  output logic signed [DATA_W-1:0]      velocity_x_o,
  output logic signed [DATA_W-1:0]      velocity_y_o,
  output logic signed [DATA_W-1:0]      velocity_z_o,
  output logic signed [DATA_W-1:0]      phase_out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAT_A,
    S_MUL_B,
    S_SAT_B,
    S_MUL_X,
    S_SAT_X,
    S_MUL_Y,
    S_SAT_Y,
    S_MUL_Z,
    S_SAT_Z,
    S_FINISH
  } state_e;

  state_e                     state_q;
  cell_rec_t                  rec_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [DATA_W-1:0]   op_q;
  logic signed [DATA_W-1:0]   fx_q, fy_q, fz_q;
  logic                       out_valid_q;
  logic signed [DATA_W-1:0]   density_q, vx_q, vy_q, vz_q, phase_q;

  logic signed [DATA_W-1:0]   mul_a, mul_b;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_shift;
  logic signed [DATA_W-1:0]   prod_sat;
  logic signed [DATA_W-1:0]   fz_sat;
  logic signed [DATA_W-1:0]   dens_sat, vx_sat, vy_sat, vz_sat;
  logic                       load;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = op_q;
    mul_b = rec_q.normal_magnitude;
    unique case (state_q)
      S_IDLE: begin
        mul_a = gamma_i;
        mul_b = rec_i.curvature;
      end
      S_MUL_X: mul_b = rec_q.normal_x;
      S_MUL_Y: mul_b = rec_q.normal_y;
      S_MUL_Z: mul_b = rec_q.normal_z;
      default: begin
        mul_a = op_q;
        mul_b = rec_q.normal_magnitude;
      end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign prod_shift = prod_q >>> FRAC_BITS;
  assign prod_sat   = sat32(WIDE_W'(prod_shift));
  assign fz_sat     = sat32(WIDE_W'(prod_shift) + WIDE_W'(body_force_z_i));

  // Density clamped; momentum minus half the force, clamped
  assign dens_sat = sat32(WIDE_W'(rec_q.density));
  assign vx_sat   = sat32(WIDE_W'(rec_q.mom_x) - WIDE_W'(fx_q >>> 1));
  assign vy_sat   = sat32(WIDE_W'(rec_q.mom_y) - WIDE_W'(fy_q >>> 1));
  assign vz_sat   = sat32(WIDE_W'(rec_q.mom_z) - WIDE_W'(fz_q >>> 1));

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign load    = (state_q == S_FINISH) && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;

  assign density_o    = density_q;
  assign velocity_x_o = vx_q;
  assign velocity_y_o = vy_q;
  assign velocity_z_o = vz_q;
  assign phase_out_o  = phase_q;

  // Sequence the force chain and hold the result until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rec_q       <= '0;
      prod_q      <= '0;
      op_q        <= '0;
      fx_q        <= '0;
      fy_q        <= '0;
      fz_q        <= '0;
      out_valid_q <= 1'b0;
      density_q   <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      phase_q     <= '0;
    end else begin
      if (pop_i && out_valid_q && !load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            rec_q   <= rec_i;
            prod_q  <= prod;
            state_q <= S_SAT_A;
          end
        end
        S_SAT_A: begin
          op_q    <= prod_sat;
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_q  <= prod;
          state_q <= S_SAT_B;
        end
        S_SAT_B: begin
          op_q    <= prod_sat >>> 1;
          state_q <= S_MUL_X;
        end
        S_MUL_X: begin
          prod_q  <= prod;
          state_q <= S_SAT_X;
        end
        S_SAT_X: begin
          fx_q    <= prod_sat;
          state_q <= S_MUL_Y;
        end
        S_MUL_Y: begin
          prod_q  <= prod;
          state_q <= S_SAT_Y;
        end
        S_SAT_Y: begin
          fy_q    <= prod_sat;
          state_q <= S_MUL_Z;
        end
        S_MUL_Z: begin
          prod_q  <= prod;
          state_q <= S_SAT_Z;
        end
        S_SAT_Z: begin
          fz_q    <= fz_sat;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (load) begin
            out_valid_q <= 1'b1;
            density_q   <= rec_q.solid ? '0 : dens_sat;
            vx_q        <= rec_q.solid ? '0 : vx_sat;
            vy_q        <= rec_q.solid ? '0 : vy_sat;
            vz_q        <= rec_q.solid ? '0 : vz_sat;
            phase_q     <= rec_q.solid ? '0 : rec_q.phase;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LBM_ASSERT(a_qpop_idle, q_pop_o |-> (state_q == S_IDLE), "queue read outside idle")
  `LBM_ASSERT(a_load_valid, load |=> out_valid_q, "result load did not raise valid")
  `LBM_ASSERT(a_solid_zero, (load && rec_q.solid) |=> (density_q == '0 && phase_q == '0), "solid cell result not zero")
  `LBM_ASSERT_RST(a_reset_empty, !rst_ni |=> empty_o, "result present after reset")

endmodule

`default_nettype wire

/* hdl/lbm_d3q19_moment_unit.sv */
// D3Q19 moment unit: direction stream in, one moment result per cell out.
// Block usage:
//   Input queue side: drive push with one direction item (0..18 of a cell);
//   it is taken at an edge where push is high and full is low. Directions
//   above 18 are dropped without effect. Direction 0 restarts the sums and
//   direction 18 closes the cell and produces its result.
//   Result queue side: while empty is low the oldest result is on the output
//   ports; pop at an edge with empty low takes it.
//   Configuration: cfg_valid_i/cfg_ready_o with index 0 surface tension and
//   index 1 body force z; ready is always high; write only while idle.
// Timing: one direction item per cycle while full is low; accumulation is
//   one add per sum. A closed cell runs through a single shared 32x32
//   multiplier sequenced by the back-end states, which take a new cell only
//   once the previous one is loaded as a result. A two-entry queue between
//   front and back absorbs closures; full rises when both entries wait (cells
//   closing faster than the back end, or a receiver stall) and holds input.
// Reset: asynchronous, active low; clears sums, queue, sequencer, result
//   valid and both configuration registers.
// Depends on lbm_mom_pkg, lbm_mom_front, lbm_mom_fifo, lbm_mom_back.
`default_nettype none

module lbm_d3q19_moment_unit
  import lbm_mom_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input queue
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [DIR_W-1:0]            direction_i,
  input  wire logic signed [DATA_W-1:0]    pdf_first_i,
  input  wire logic signed [DATA_W-1:0]    pdf_second_i,
  input  wire logic                        solid_i,
  input  wire logic signed [DATA_W-1:0]    curvature_i,
  input  wire logic signed [DATA_W-1:0]    normal_magnitude_i,
  input  wire logic signed [DATA_W-1:0]    normal_x_i,
  input  wire logic signed [DATA_W-1:0]    normal_y_i,
  input  wire logic signed [DATA_W-1:0]    normal_z_i,
  input  wire logic signed [DATA_W-1:0]    phase_in_i,
  // Result queue
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [DATA_W-1:0]         density_o,
  output logic signed [DATA_W-1:0]         velocity_x_o,
  output logic signed [DATA_W-1:0]         velocity_y_o,
  output logic signed [DATA_W-1:0]         velocity_z_o,
  output logic signed [DATA_W-1:0]         phase_out_o,
  // Configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [DATA_W-1:0]           cfg_data_i
);

  logic signed [DATA_W-1:0] gamma_q;
  logic signed [DATA_W-1:0] body_force_z_q;
  logic                     accept;
  logic                     f_push;
  cell_rec_t                f_rec;
  logic                     q_full, q_empty, q_pop;
  cell_rec_t                q_rec;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q        <= '0;
      body_force_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SURFACE_TENSION: gamma_q        <= cfg_data_i;
        CFG_BODY_FORCE_Z:    body_force_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lbm_mom_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .direction_i        (direction_i),
    .pdf_first_i        (pdf_first_i),
    .pdf_second_i       (pdf_second_i),
    .solid_i            (solid_i),
    .curvature_i        (curvature_i),
    .normal_magnitude_i (normal_magnitude_i),
    .normal_x_i         (normal_x_i),
    .normal_y_i         (normal_y_i),
    .normal_z_i         (normal_z_i),
    .phase_in_i         (phase_in_i),
    .push_o             (f_push),
    .rec_o              (f_rec)
  );

  lbm_mom_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rec),
    .empty_o (q_empty)
  );

  lbm_mom_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .gamma_i        (gamma_q),
    .body_force_z_i (body_force_z_q),
    .q_empty_i      (q_empty),
    .rec_i          (q_rec),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .density_o      (density_o),
    .velocity_x_o   (velocity_x_o),
    .velocity_y_o   (velocity_y_o),
    .velocity_z_o   (velocity_z_o),
    .phase_out_o    (phase_out_o)
  );

endmodule

`default_nettype wire

/* tb/tb_lbm_d3q19_moment_unit.sv */
// Self-checking testbench for lbm_d3q19_moment_unit: streams D3Q19 cells and
// compares every moment result against a predictor kept in this module.
// Depends on lbm_mom_pkg and the RTL of the block.
`default_nettype none

module tb_lbm_d3q19_moment_unit
  import lbm_mom_pkg::*;
();

  localparam int unsigned FRAC          = 24;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned LIMIT_CYCLES  = 250000;
  localparam int unsigned MAX_REPORTS   = 10;

  // One direction item as presented on the input ports
  typedef struct packed {
    logic [DIR_W-1:0]         dir;
    logic signed [DATA_W-1:0] pdf_first;
    logic signed [DATA_W-1:0] pdf_second;
    logic                     solid;
    logic signed [DATA_W-1:0] curvature;
    logic signed [DATA_W-1:0] normal_mag;
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic signed [DATA_W-1:0] normal_z;
    logic signed [DATA_W-1:0] phase;
  } dir_item_t;

  // density, velocity x/y/z, phase
  typedef logic [4:0][DATA_W-1:0] moment_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      push     = 1'b0;
  logic      full;
  dir_item_t drv_item = '0;
  logic      empty;
  logic      pop      = 1'b0;
  moment_t   got_moment;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  lbm_d3q19_moment_unit #(.FRAC_BITS(FRAC)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .direction_i        (drv_item.dir),
    .pdf_first_i        (drv_item.pdf_first),
    .pdf_second_i       (drv_item.pdf_second),
    .solid_i            (drv_item.solid),
    .curvature_i        (drv_item.curvature),
    .normal_magnitude_i (drv_item.normal_mag),
    .normal_x_i         (drv_item.normal_x),
    .normal_y_i         (drv_item.normal_y),
    .normal_z_i         (drv_item.normal_z),
    .phase_in_i         (drv_item.phase),
    .empty              (empty),
    .pop                (pop),
    .density_o          (got_moment[0]),
    .velocity_x_o       (got_moment[1]),
    .velocity_y_o       (got_moment[2]),
    .velocity_z_o       (got_moment[3]),
    .phase_out_o        (got_moment[4]),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  // Lattice velocity components per direction
  int step_x [19] = '{0, 1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  int step_y [19] = '{0, 0, 0, 1, -1, 0, 0, 1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
  int step_z [19] = '{0, 0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
  string field_name [5] = '{"density", "velocity_x", "velocity_y", "velocity_z", "phase_out"};

  // Predictor state and register copies
  logic signed [39:0]       den_acc = '0;
  logic signed [39:0]       mx_acc  = '0;
  logic signed [39:0]       my_acc  = '0;
  logic signed [39:0]       mz_acc  = '0;
  logic signed [DATA_W-1:0] gamma_reg   = '0;
  logic signed [DATA_W-1:0] body_fz_reg = '0;

  moment_t   moment_q [$];
  dir_item_t pending  [$];

  int   items_queued   = 0;
  int   items_accepted = 0;
  int   cells_closed   = 0;
  int   solid_cells    = 0;
  int   ignored_items  = 0;
  int   results_seen   = 0;
  int   cfg_writes     = 0;
  int   mismatches     = 0;
  int   cycle_cnt      = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  logic took_item      = 1'b0;

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (x < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
    return x;
  endfunction

  // Accumulate one direction; close the cell and predict its moments on the last one
  task automatic fold_direction(input dir_item_t it);
    longint  ft, a, b, t, fx, fy, fz;
    moment_t m;
    if (it.dir > LAST_DIR) begin
      ignored_items++;
      return;
    end
    if (it.dir == FIRST_DIR) begin
      den_acc = '0;
      mx_acc  = '0;
      my_acc  = '0;
      mz_acc  = '0;
    end
    ft = longint'(it.pdf_first) + longint'(it.pdf_second);
    den_acc = ACC_W'(den_acc + ft);
    mx_acc  = ACC_W'(mx_acc + ft * step_x[it.dir]);
    my_acc  = ACC_W'(my_acc + ft * step_y[it.dir]);
    mz_acc  = ACC_W'(mz_acc + ft * step_z[it.dir]);
    if (it.dir != LAST_DIR) return;

    // Interfacial force, body force on z
    a  = clamp32((longint'(gamma_reg) * longint'(it.curvature)) >>> FRAC);
    b  = clamp32((a * longint'(it.normal_mag)) >>> FRAC);
    t  = b >>> 1;
    fx = clamp32((t * longint'(it.normal_x)) >>> FRAC);
    fy = clamp32((t * longint'(it.normal_y)) >>> FRAC);
    fz = clamp32(((t * longint'(it.normal_z)) >>> FRAC) + longint'(body_fz_reg));
    if (it.solid) begin
      m = '0;
      solid_cells++;
    end else begin
      m[0] = DATA_W'(clamp32(longint'(den_acc)));
      m[1] = DATA_W'(clamp32(longint'(mx_acc) - (fx >>> 1)));
      m[2] = DATA_W'(clamp32(longint'(my_acc) - (fy >>> 1)));
      m[3] = DATA_W'(clamp32(longint'(mz_acc) - (fz >>> 1)));
      m[4] = it.phase;
    end
    moment_q.push_back(m);
    cells_closed++;
    den_acc = '0;
    mx_acc  = '0;
    my_acc  = '0;
    mz_acc  = '0;
  endtask

  // Monitor: track register writes, predict accepted items, check results
  always @(posedge clk_i) begin : monitor
    moment_t want;
    int      i;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, moment_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst_ni) begin
      took_item <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == CFG_SURFACE_TENSION) gamma_reg = cfg_data;
        else if (cfg_index == CFG_BODY_FORCE_Z) body_fz_reg = cfg_data;
      end
      if (push && !full) begin
        items_accepted++;
        fold_direction(drv_item);
      end
      took_item <= push && !full;
      if (pop && !empty) begin
        results_seen++;
        if (moment_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transaction: density %h phase %h",
                     got_moment[0], got_moment[4]);
        end else begin
          want = moment_q.pop_front();
          for (i = 0; i < 5; i++) begin
            if (got_moment[i] !== want[i]) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("result %0d %s: expected %h, got %h",
                         results_seen, field_name[i], want[i], got_moment[i]);
            end
          end
        end
      end
    end
  end

  // Driver: present pending items, hold each until taken, idle at random
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (took_item) pending.delete(0);
      if (push && !took_item) begin
        push <= 1'b1;
      end else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item <= pending[0];
        push     <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk_i) begin : receiver
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [DATA_W-1:0] rand_q();
    logic [DATA_W-1:0] r;
    r = $urandom();
    case ($urandom_range(0, 4))
      0: return r;
      1: return {{5{r[26]}}, r[26:0]};
      2: return {{7{r[24]}}, r[24:0]};
      3: return {{12{r[19]}}, r[19:0]};
      default: begin
        case (r[1:0])
          2'd0: return 32'h7FFF_FFFF;
          2'd1: return 32'h8000_0000;
          2'd2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic dir_item_t random_item(input int d, input logic solid);
    dir_item_t it;
    it.dir        = d[DIR_W-1:0];
    it.pdf_first  = rand_q();
    it.pdf_second = rand_q();
    it.solid      = solid;
    it.curvature  = rand_q();
    it.normal_mag = rand_q();
    it.normal_x   = rand_q();
    it.normal_y   = rand_q();
    it.normal_z   = rand_q();
    it.phase      = rand_q();
    return it;
  endfunction

  function automatic void add_item(input dir_item_t it);
    pending.push_back(it);
    items_queued++;
  endfunction

  function automatic dir_item_t make_item(input int d, input logic [31:0] p1, input logic [31:0] p2);
    dir_item_t it;
    it            = '0;
    it.dir        = d[DIR_W-1:0];
    it.pdf_first  = p1;
    it.pdf_second = p2;
    return it;
  endfunction

  // Mostly whole cells with random content; some broken cells and noise
  task automatic queue_cells(input int n_items);
    int   made, pick, first, last, d, k, n_noise;
    logic solid;
    made = 0;
    while (made < n_items) begin
      pick  = $urandom_range(99);
      solid = ($urandom_range(3) == 0);
      if (pick < 80) begin
        first = 0;
        last  = 18;
      end else if (pick < 90) begin
        first = $urandom_range(0, 18);
        last  = $urandom_range(first, 18);
      end else begin
        first = 19;
        last  = 18;
      end
      for (d = first; d <= last; d++) begin
        add_item(random_item(d, solid));
        made++;
      end
      if (pick >= 90) begin
        n_noise = $urandom_range(1, 3);
        for (k = 0; k < n_noise; k++) add_item(random_item($urandom_range(19, 31), solid));
      end
    end
  endtask

  // Wait until every queued item is taken and every result has come, then settle
  task automatic drain();
    do @(negedge clk_i); while (items_accepted != items_queued || moment_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Write both registers and pick the idling profile; block must be idle here
  task automatic start_phase(input logic [31:0] gam, input logic [31:0] bfz, input int mode);
    write_reg(CFG_SURFACE_TENSION, gam);
    write_reg(CFG_BODY_FORCE_Z, bfz);
    case (mode)
      0: begin
        send_idle_pct = 12;
        recv_idle_pct = 84;
      end
      1: begin
        send_idle_pct = 84;
        recv_idle_pct = 12;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin : stimulus
    dir_item_t it;
    int        d;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme registers, leftover sum discarded by direction zero
    start_phase(32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_item(make_item(4, 32'h1234_5678, 32'h0100_0000));
    for (d = 0; d < 18; d++) begin
      case (d % 3)
        0: add_item(make_item(d, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        1: add_item(make_item(d, 32'h8000_0000, 32'h8000_0000));
        default: add_item(make_item(d, 32'h0000_0000, 32'hFFFF_FFFF));
      endcase
    end
    it            = make_item(18, 32'h7FFF_FFFF, 32'h8000_0000);
    it.curvature  = 32'h7FFF_FFFF;
    it.normal_mag = 32'h7FFF_FFFF;
    it.normal_x   = 32'h8000_0000;
    it.normal_y   = 32'h7FFF_FFFF;
    it.normal_z   = 32'hFFFF_FFFF;
    it.phase      = 32'h7FFF_FFFF;
    add_item(it);
    // Directions above the last one are dropped
    add_item(make_item(19, 32'h8000_0000, 32'h8000_0000));
    add_item(make_item(31, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // Cell without a direction zero, closed as a solid wall
    add_item(make_item(7, 32'h0200_0000, 32'h0080_0000));
    it           = make_item(18, 32'h0100_0000, 32'h0100_0000);
    it.solid     = 1'b1;
    it.curvature = 32'h0100_0000;
    it.phase     = 32'h8000_0000;
    add_item(it);
    drain();

    // Random cells across register settings and idling profiles
    start_phase(32'h0100_0000, 32'h0040_0000, 0);
    queue_cells(115);
    drain();
    start_phase(32'h8000_0000, 32'h7FFF_FFFF, 0);
    queue_cells(115);
    drain();
    start_phase(32'h0000_0000, 32'h0000_0000, 1);
    queue_cells(115);
    drain();
    start_phase($urandom(), $urandom(), 1);
    queue_cells(60);
    // Hold off the sender until the block has delivered everything
    drain();
    queue_cells(55);
    drain();
    start_phase(32'hFF00_0000, rand_q(), 2);
    queue_cells(115);
    drain();
    start_phase(rand_q(), $urandom(), 2);
    queue_cells(115);
    drain();

    $display("covered %0d cells (%0d solid), %0d dropped directions, %0d register writes",
             cells_closed, solid_cells, ignored_items, cfg_writes);
    $display("checked %0d result transactions in %0d cycles, %0d mismatches",
             results_seen, cycle_cnt, mismatches);
    if (mismatches == 0 && moment_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
